// File: hw/rtl/circular_queue_engine_top_assert.svh
// Assertion macros used by the queue engine back end (cqe_back).
`ifndef CIRCULAR_QUEUE_ENGINE_TOP_ASSERT_SVH
`define CIRCULAR_QUEUE_ENGINE_TOP_ASSERT_SVH

// Condition a implies condition c in the same cycle.
`define CQE_ASSERT_IMPLY(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("implication check failed");

// Condition a implies condition c in the next cycle.
`define CQE_ASSERT_NEXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("next-cycle check failed");

// Condition a never holds.
`define CQE_ASSERT_NEVER(lbl, clk, rst, a) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(a)) \
    else $error("forbidden condition seen");

`endif

// File: hw/rtl/cqe_pkg.sv
package cqe_pkg;

  // Command codes on the input
  localparam logic [1:0] CMD_ENQ  = 2'd0;
  localparam logic [1:0] CMD_DEQ  = 2'd1;
  localparam logic [1:0] CMD_DISP = 2'd2;

  // Status codes on the results
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  // Capacity register
  localparam int QSIZE_W     = 7;
  localparam int QSIZE_RESET = 64;

  // Most results one display may emit
  localparam int MAX_RESULTS = 64;
  localparam int CNT_W       = $clog2(MAX_RESULTS);

  typedef struct packed {
    logic        [1:0]  cmd;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic        [1:0]  status;
    logic signed [31:0] data;
    logic               last;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_ENQ,
    OP_DEQ,
    OP_DISP
  } op_t;

  typedef struct packed {
    op_t                op;
    logic signed [31:0] value;
  } cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DEQ_OUT,
    S_DISP_OUT
  } state_t;

endpackage

// File: hw/rtl/cqe_fifo.sv
module cqe_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             rd,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic [1:0]       count_next;
  logic             do_wr;
  logic             do_rd;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = mem[rd_ptr];

  // Track occupancy
  always_comb begin
    count_next = count;
    if (do_wr && !do_rd) begin
      count_next = count + 2'd1;
    end else if (do_rd && !do_wr) begin
      count_next = count - 2'd1;
    end
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_rd) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count_next;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

// File: hw/rtl/cqe_front.sv
module cqe_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  cqe_pkg::in_item_t item,
  input  logic              cmd_pop,
  output logic              cmd_empty,
  output cqe_pkg::cmd_t     cmd
);

  cqe_pkg::cmd_t cmd_in;
  logic          keep;

  // Decode the command; drop unknown codes
  always_comb begin
    cmd_in.value = item.value;
    cmd_in.op    = cqe_pkg::OP_ENQ;
    keep         = 1'b1;
    case (item.cmd)
      cqe_pkg::CMD_ENQ:  cmd_in.op = cqe_pkg::OP_ENQ;
      cqe_pkg::CMD_DEQ:  cmd_in.op = cqe_pkg::OP_DEQ;
      cqe_pkg::CMD_DISP: cmd_in.op = cqe_pkg::OP_DISP;
      default:           keep = 1'b0;
    endcase
  end

  // Hold decoded commands for the back end
  cqe_fifo #(
    .WIDTH($bits(cqe_pkg::cmd_t))
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .wr    (push && keep),
    .wdata (cmd_in),
    .full  (full),
    .rd    (cmd_pop),
    .rdata (cmd),
    .empty (cmd_empty)
  );

endmodule

// File: hw/rtl/cqe_back.sv
`include "circular_queue_engine_top_assert.svh"

module cqe_back #(
  parameter int DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [cqe_pkg::QSIZE_W-1:0]   cfg_size,
  input  logic                          cmd_empty,
  input  cqe_pkg::cmd_t                 cmd,
  output logic                          cmd_pop,
  input  logic                          res_full,
  output logic                          res_push,
  output cqe_pkg::out_item_t            res,
  output logic                          idle
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [IW-1:0] RESET_CAP_M1 =
    IW'(((DEPTH < cqe_pkg::QSIZE_RESET) ? DEPTH : cqe_pkg::QSIZE_RESET) - 1);

  cqe_pkg::state_t state, state_next;
  logic [IW-1:0]   head, head_next;
  logic [IW-1:0]   tail, tail_next;
  logic            qempty, qempty_next;
  logic [IW-1:0]   cap_m1, cap_m1_next;
  logic [IW-1:0]   idx, idx_next;
  logic [cqe_pkg::CNT_W-1:0] cnt, cnt_next;

  logic signed [31:0] store [DEPTH];
  logic signed [31:0] rd_data;
  logic               wr_en;
  logic [IW-1:0]      wr_addr;
  logic               rd_en;
  logic [IW-1:0]      rd_addr;
  logic               disp_done;
  logic               deq_start;

  function automatic logic [IW-1:0] adv(input logic [IW-1:0] i, input logic [IW-1:0] lim);
    adv = (i == lim) ? '0 : IW'(i + 1'b1);
  endfunction

  assign idle      = (state == cqe_pkg::S_IDLE);
  assign disp_done = (idx == tail) || (cnt == cqe_pkg::CNT_W'(cqe_pkg::MAX_RESULTS - 1)) ||
                     (32'(cnt) == DEPTH - 1);
  assign deq_start = cmd_pop && (cmd.op == cqe_pkg::OP_DEQ) && !qempty;

  // Sequence commands and drive the item store
  always_comb begin
    state_next  = state;
    head_next   = head;
    tail_next   = tail;
    qempty_next = qempty;
    cap_m1_next = cap_m1;
    idx_next    = idx;
    cnt_next    = cnt;
    cmd_pop     = 1'b0;
    res_push    = 1'b0;
    res.status  = cqe_pkg::STAT_OK;
    res.data    = '0;
    res.last    = 1'b1;
    wr_en       = 1'b0;
    wr_addr     = adv(tail, cap_m1);
    rd_en       = 1'b0;
    rd_addr     = head;
    case (state)
      cqe_pkg::S_IDLE: begin
        if (cfg_we) begin
          // Clamp capacity and empty the queue
          if (cfg_size == '0) begin
            cap_m1_next = '0;
          end else if (32'(cfg_size) > DEPTH) begin
            cap_m1_next = IW'(DEPTH - 1);
          end else begin
            cap_m1_next = IW'(cfg_size - 1'b1);
          end
          head_next   = '0;
          tail_next   = '0;
          qempty_next = 1'b1;
        end else if (!cmd_empty && !res_full) begin
          cmd_pop = 1'b1;
          case (cmd.op)
            cqe_pkg::OP_ENQ: begin
              res_push = 1'b1;
              if (qempty) begin
                head_next   = '0;
                tail_next   = '0;
                qempty_next = 1'b0;
                wr_en       = 1'b1;
                wr_addr     = '0;
              end else if (adv(tail, cap_m1) == head) begin
                res.status = cqe_pkg::STAT_FULL;
              end else begin
                tail_next = adv(tail, cap_m1);
                wr_en     = 1'b1;
              end
            end
            cqe_pkg::OP_DEQ: begin
              if (qempty) begin
                res_push   = 1'b1;
                res.status = cqe_pkg::STAT_EMPTY;
              end else begin
                rd_en = 1'b1;
                if (head == tail) begin
                  head_next   = '0;
                  tail_next   = '0;
                  qempty_next = 1'b1;
                end else begin
                  head_next = adv(head, cap_m1);
                end
                state_next = cqe_pkg::S_DEQ_OUT;
              end
            end
            cqe_pkg::OP_DISP: begin
              if (qempty) begin
                res_push   = 1'b1;
                res.status = cqe_pkg::STAT_EMPTY;
              end else begin
                rd_en      = 1'b1;
                idx_next   = head;
                cnt_next   = '0;
                state_next = cqe_pkg::S_DISP_OUT;
              end
            end
            default: ;
          endcase
        end
      end
      cqe_pkg::S_DEQ_OUT: begin
        if (!res_full) begin
          res_push   = 1'b1;
          res.data   = rd_data;
          state_next = cqe_pkg::S_IDLE;
        end
      end
      cqe_pkg::S_DISP_OUT: begin
        // Emit one entry and, unless it is the last, fetch the next
        if (!res_full) begin
          res_push = 1'b1;
          res.data = rd_data;
          res.last = disp_done;
          if (disp_done) begin
            state_next = cqe_pkg::S_IDLE;
          end else begin
            idx_next = adv(idx, cap_m1);
            cnt_next = cnt + 1'b1;
            rd_en    = 1'b1;
            rd_addr  = adv(idx, cap_m1);
          end
        end
      end
      default: state_next = cqe_pkg::S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= cqe_pkg::S_IDLE;
      head   <= '0;
      tail   <= '0;
      qempty <= 1'b1;
      cap_m1 <= RESET_CAP_M1;
    end else begin
      state  <= state_next;
      head   <= head_next;
      tail   <= tail_next;
      qempty <= qempty_next;
      cap_m1 <= cap_m1_next;
    end
  end

  // Walk position of a display
  always_ff @(posedge clk) begin
    idx <= idx_next;
    cnt <= cnt_next;
  end

  // Item store write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= cmd.value;
    end
  end

  // Item store registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= store[rd_addr];
    end
  end

  `CQE_ASSERT_IMPLY(a_empty_at_origin, clk, rst, qempty, head == '0 && tail == '0)
  `CQE_ASSERT_IMPLY(a_idx_in_range, clk, rst, 1'b1, head <= cap_m1 && tail <= cap_m1)
  `CQE_ASSERT_NEVER(a_one_port_op, clk, rst, rd_en && wr_en)
  `CQE_ASSERT_NEXT(a_deq_reads, clk, rst, deq_start, state == cqe_pkg::S_DEQ_OUT)

endmodule

// File: hw/rtl/circular_queue_engine_top.sv
// Circular FIFO queue engine. Each input item (cmd, value) enters a two-entry command
// queue; the back end executes commands one at a time against a DEPTH-entry item store
// with a registered read port, and results leave through a two-entry result queue.
// A dequeue returns the item from the store's registered read port. A display reads
// one entry ahead, then emits one result per cycle while the result queue has room,
// at most 64 results. Unknown commands are dropped at the input. Writing queue_size
// (clamped to 1..DEPTH) empties the queue; cfg_ready is high only while no command
// is queued or running.
module circular_queue_engine_top #(
  parameter int DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  cqe_pkg::in_item_t             item,
  input  logic                          pop,
  output logic                          empty,
  output cqe_pkg::out_item_t            result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cqe_pkg::QSIZE_W-1:0]   cfg_data
);

  logic               cmd_pop;
  logic               cmd_empty;
  cqe_pkg::cmd_t      cmd;
  logic               res_full;
  logic               res_push;
  cqe_pkg::out_item_t res;
  logic               back_idle;

  assign cfg_ready = back_idle && cmd_empty;

  // Accept and decode commands
  cqe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .cmd_pop   (cmd_pop),
    .cmd_empty (cmd_empty),
    .cmd       (cmd)
  );

  // Execute commands against the store
  cqe_back #(
    .DEPTH(DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_size  (cfg_data),
    .cmd_empty (cmd_empty),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res),
    .idle      (back_idle)
  );

  // Hold results until taken
  cqe_fifo #(
    .WIDTH($bits(cqe_pkg::out_item_t))
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .wr    (res_push),
    .wdata (res),
    .full  (res_full),
    .rd    (pop),
    .rdata (result),
    .empty (empty)
  );

endmodule
